// ----- rtl/tdfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tdfa_pkg;

  localparam int NUM_STATES = 256;
  localparam int MAX_LENGTH = 1024;

  localparam int ST_W  = 8;
  localparam int SYM_W = 8;

  // Only states that both the state fields can name and NUM_STATES allows get storage.
  localparam int STATE_AW  = (NUM_STATES > (1 << ST_W)) ? ST_W : $clog2(NUM_STATES);
  localparam int TT_AW     = STATE_AW + SYM_W;
  localparam int TT_DEPTH  = 1 << TT_AW;
  localparam int ACC_DEPTH = 1 << STATE_AW;
  localparam int CNT_W     = $clog2(MAX_LENGTH + 1);

  typedef enum logic [1:0] {
    CMD_WR_TRANS  = 2'd0,
    CMD_WR_ACCEPT = 2'd1,
    CMD_FEED      = 2'd2,
    CMD_FINISH    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic            valid;
    logic [ST_W-1:0] target;
  } tt_entry_t;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [TT_AW-1:0] addr;
    tt_entry_t        wdata;
  } tt_req_t;

  typedef struct packed {
    logic                wr;
    logic                rd;
    logic [STATE_AW-1:0] addr;
    logic                wdata;
  } acc_req_t;

  function automatic logic state_in_range(logic [ST_W-1:0] s);
    return (int'(s) < NUM_STATES);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tdfa_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tdfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] state_index;
  logic [7:0] symbol;
  logic [7:0] target_state;
  logic       target_valid;
  logic       accept_value;

  modport source (
    output valid, command, state_index, symbol, target_state, target_valid, accept_value,
    input  ready
  );
  modport sink (
    input  valid, command, state_index, symbol, target_state, target_valid, accept_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tdfa_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tdfa_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic dead_end;

  modport source (
    output valid, matched, dead_end,
    input  ready
  );
  modport sink (
    input  valid, matched, dead_end,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tdfa_trans_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tdfa_trans_mem (
  input  wire logic                 clk_i,
  input  wire tdfa_pkg::tt_req_t    req_i,
  output tdfa_pkg::tt_entry_t       rdata_o
);

  tdfa_pkg::tt_entry_t mem_q [tdfa_pkg::TT_DEPTH];
  tdfa_pkg::tt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/tdfa_acc_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tdfa_acc_mem (
  input  wire logic                 clk_i,
  input  wire tdfa_pkg::acc_req_t   req_i,
  output logic                      rdata_o
);

  logic mem_q [tdfa_pkg::ACC_DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/tdfa_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tdfa_walk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tdfa_in_if.sink                            in_ch,
  tdfa_out_if.source                         out_ch,
  input  wire logic [tdfa_pkg::ST_W-1:0]     start_state_i,
  input  wire logic                          busy_i,
  output tdfa_pkg::tt_req_t                  tt_req_o,
  input  wire tdfa_pkg::tt_entry_t           tt_rdata_i,
  output tdfa_pkg::acc_req_t                 acc_req_o,
  input  wire logic                          acc_rdata_i
);

  tdfa_pkg::cmd_e cmd;

  logic [tdfa_pkg::ST_W-1:0]  cur_q, cur_d, cur_eff, here;
  logic                       dead_q, dead_d, dead_eff;
  logic [tdfa_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       pend_q, pend_d;
  logic [tdfa_pkg::ST_W-1:0]  pend_here_q, pend_here_d;
  logic                       pend_oob_q, pend_oob_d;
  logic                       fin_q, fin_d;
  logic                       fin_dead_q, fin_dead_d;
  logic                       fin_oob_q, fin_oob_d;
  logic                       out_valid_q, out_valid_d;
  logic                       matched_q, matched_d;
  logic                       dead_end_q, dead_end_d;

  logic out_free, in_ready, take, here_ok, idx_ok, take_byte, fin_take;

  assign cmd      = tdfa_pkg::cmd_e'(in_ch.command);
  assign out_free = !out_valid_q || out_ch.ready;
  // A finish waiting for a full output register holds the input side.
  assign in_ready = !busy_i && !(fin_q && !out_free);
  assign take     = in_ch.valid && in_ready;

  // The transition read of the previous beat lands now and is forwarded as the state.
  always_comb begin
    if (pend_q) begin
      cur_eff = (tt_rdata_i.valid && !pend_oob_q) ? tt_rdata_i.target : pend_here_q;
    end else begin
      cur_eff = cur_q;
    end
  end

  assign dead_eff  = dead_q || (pend_q && (!tt_rdata_i.valid || pend_oob_q));
  assign here      = (cnt_q == '0) ? start_state_i : cur_eff;
  assign here_ok   = tdfa_pkg::state_in_range(here);
  assign idx_ok    = tdfa_pkg::state_in_range(in_ch.state_index);
  assign take_byte = take && (cmd == tdfa_pkg::CMD_FEED) && !dead_eff
                     && (cnt_q < tdfa_pkg::CNT_W'(tdfa_pkg::MAX_LENGTH));
  assign fin_take  = take && (cmd == tdfa_pkg::CMD_FINISH);

  always_comb begin
    tt_req_o.wr = take && (cmd == tdfa_pkg::CMD_WR_TRANS) && idx_ok;
    tt_req_o.rd = take_byte;
    if (tt_req_o.wr) begin
      tt_req_o.addr = {in_ch.state_index[tdfa_pkg::STATE_AW-1:0], in_ch.symbol};
    end else begin
      tt_req_o.addr = {here[tdfa_pkg::STATE_AW-1:0], in_ch.symbol};
    end
    tt_req_o.wdata.valid  = in_ch.target_valid;
    tt_req_o.wdata.target = in_ch.target_valid ? in_ch.target_state : '0;

    acc_req_o.wr    = take && (cmd == tdfa_pkg::CMD_WR_ACCEPT) && idx_ok;
    acc_req_o.rd    = fin_take;
    acc_req_o.addr  = acc_req_o.wr ? in_ch.state_index[tdfa_pkg::STATE_AW-1:0]
                                   : here[tdfa_pkg::STATE_AW-1:0];
    acc_req_o.wdata = in_ch.accept_value;
  end

  always_comb begin
    cur_d       = cur_eff;
    dead_d      = dead_eff;
    cnt_d       = cnt_q;
    pend_d      = take_byte;
    pend_here_d = here;
    pend_oob_d  = !here_ok;
    if (take_byte) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (fin_take) begin
      cur_d  = start_state_i;
      dead_d = 1'b0;
      cnt_d  = '0;
    end
  end

  always_comb begin
    fin_d      = fin_q;
    fin_dead_d = fin_dead_q;
    fin_oob_d  = fin_oob_q;
    if (fin_take) begin
      fin_d      = 1'b1;
      fin_dead_d = dead_eff;
      fin_oob_d  = !here_ok;
    end else if (fin_q && out_free) begin
      fin_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    dead_end_d  = dead_end_q;
    if (fin_q && out_free) begin
      out_valid_d = 1'b1;
      matched_d   = acc_rdata_i && !fin_dead_q && !fin_oob_q;
      dead_end_d  = fin_dead_q;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      dead_q      <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      dead_q      <= dead_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_here_q <= pend_here_d;
    pend_oob_q  <= pend_oob_d;
    fin_dead_q  <= fin_dead_d;
    fin_oob_q   <= fin_oob_d;
    matched_q   <= matched_d;
    dead_end_q  <= dead_end_d;
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_q;
  assign out_ch.matched  = matched_q;
  assign out_ch.dead_end = dead_end_q;

  a_single_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tt_req_o.wr && tt_req_o.rd))
    else $error("transition memory written and read in one cycle");

  a_cnt_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tdfa_pkg::CNT_W'(tdfa_pkg::MAX_LENGTH))
    else $error("byte count passed the length limit");

  a_finish_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take |=> (cnt_q == '0 && !dead_q && !pend_q && fin_q))
    else $error("string state not cleared after finish");

  a_hold_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !in_ch.ready)
    else $error("input taken during the table clear");

endmodule

`default_nettype wire

// ----- rtl/table_dfa_string_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in_ch     in   valid / ready        command, state_index, symbol, target_state,
//                                     target_valid, accept_value
// out_ch    out  valid / ready        matched, dead_end
// cfg       in   cfg_we_i             cfg_wdata_i (start_state)
//
// One input beat is taken per cycle while in_ch.ready is high; a fed byte reads the
// transition memory and the read data is forwarded as the state of the next byte, so
// bytes stream at one per cycle unless the input side stalls. A finish reads the accept
// flag memory; the flag is registered and moves into the output register once it is free.
// After reset a clearing pass writes every transition entry (TT_DEPTH entries, 65536
// for 256 states) and the accept flags; in_ch.ready stays low until it ends.
// A finish that finds the output register full stalls the input side until out_ch.ready.

module table_dfa_string_matcher (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tdfa_in_if.sink         in_ch,
  tdfa_out_if.source      out_ch,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic [tdfa_pkg::ST_W-1:0]  start_q, start_d;
  logic                       clr_q, clr_d;
  logic [tdfa_pkg::TT_AW-1:0] clr_cnt_q, clr_cnt_d;

  tdfa_pkg::tt_req_t   walk_tt_req, tt_req;
  tdfa_pkg::acc_req_t  walk_acc_req, acc_req;
  tdfa_pkg::tt_entry_t tt_rdata;
  logic                acc_rdata;

  always_comb begin
    start_d   = cfg_we_i ? cfg_wdata_i : start_q;
    clr_d     = clr_q && (clr_cnt_q != '1);
    clr_cnt_d = clr_q ? clr_cnt_q + 1'b1 : clr_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      start_q   <= start_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // The clearing pass owns both memory ports until the last entry is written.
  always_comb begin
    if (clr_q) begin
      tt_req.wr     = 1'b1;
      tt_req.rd     = 1'b0;
      tt_req.addr   = clr_cnt_q;
      tt_req.wdata  = '0;
      acc_req.wr    = 1'b1;
      acc_req.rd    = 1'b0;
      acc_req.addr  = clr_cnt_q[tdfa_pkg::STATE_AW-1:0];
      acc_req.wdata = 1'b0;
    end else begin
      tt_req  = walk_tt_req;
      acc_req = walk_acc_req;
    end
  end

  tdfa_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .start_state_i (start_q),
    .busy_i        (clr_q),
    .tt_req_o      (walk_tt_req),
    .tt_rdata_i    (tt_rdata),
    .acc_req_o     (walk_acc_req),
    .acc_rdata_i   (acc_rdata)
  );

  tdfa_trans_mem u_trans_mem (
    .clk_i   (clk_i),
    .req_i   (tt_req),
    .rdata_o (tt_rdata)
  );

  tdfa_acc_mem u_acc_mem (
    .clk_i   (clk_i),
    .req_i   (acc_req),
    .rdata_o (acc_rdata)
  );

endmodule

`default_nettype wire

// ----- test/table_dfa_string_matcher_checker.sv -----
`timescale 1ns / 1ps

module table_dfa_string_matcher_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tdfa_in_if              in_mon,
  tdfa_out_if             out_mon,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              verdicts_o,
  output int              matches_o,
  output int              dead_ends_o
);
  import tdfa_pkg::*;

  typedef struct packed {
    logic matched;
    logic dead_end;
  } verdict_t;

  verdict_t   verdict_q[$];
  logic [8:0] next_tbl [TT_DEPTH];
  logic       accept_tbl [ACC_DEPTH];
  logic [7:0] start_state;
  logic [7:0] walk_state;
  logic       walk_dead;
  int         walk_len;
  int         mismatches;
  int         verdict_cnt;
  int         match_cnt;
  int         dead_cnt;

  always @(posedge clk_i or negedge rst_ni) begin : predict
    verdict_t   want;
    verdict_t   got;
    logic [7:0] here;
    logic [8:0] entry;
    if (!rst_ni) begin
      for (int i = 0; i < TT_DEPTH; i++) next_tbl[i] = '0;
      for (int i = 0; i < ACC_DEPTH; i++) accept_tbl[i] = 1'b0;
      verdict_q.delete();
      start_state = '0;
      walk_state  = '0;
      walk_dead   = 1'b0;
      walk_len    = 0;
      mismatches  = 0;
      verdict_cnt = 0;
      match_cnt   = 0;
      dead_cnt    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      verdicts_o   <= 0;
      matches_o    <= 0;
      dead_ends_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        start_state = cfg_wdata_i;
      end

      // Results are compared before this edge's input beat is predicted, so a
      // verdict pushed now can never be matched against an older result.
      if (out_mon.valid && out_mon.ready) begin
        got.matched  = out_mon.matched;
        got.dead_end = out_mon.dead_end;
        verdict_cnt++;
        if (got.matched === 1'b1) match_cnt++;
        if (got.dead_end === 1'b1) dead_cnt++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected verdict: matched=%b dead_end=%b", $realtime,
                     got.matched, got.dead_end);
          end
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] verdict mismatch: expected matched=%b dead_end=%b, got matched=%b dead_end=%b",
                       $realtime, want.matched, want.dead_end, got.matched, got.dead_end);
            end
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (cmd_e'(in_mon.command))
          CMD_WR_TRANS: begin
            if (int'(in_mon.state_index) < NUM_STATES) begin
              next_tbl[{in_mon.state_index, in_mon.symbol}] =
                in_mon.target_valid ? {1'b1, in_mon.target_state} : 9'd0;
            end
          end
          CMD_WR_ACCEPT: begin
            if (int'(in_mon.state_index) < NUM_STATES) begin
              accept_tbl[in_mon.state_index] = in_mon.accept_value;
            end
          end
          CMD_FEED: begin
            // A dead string or one at the length limit ignores further bytes.
            if (!walk_dead && walk_len < MAX_LENGTH) begin
              here  = (walk_len == 0) ? start_state : walk_state;
              entry = (int'(here) < NUM_STATES) ? next_tbl[{here, in_mon.symbol}] : 9'd0;
              walk_len++;
              if (entry[8]) begin
                walk_state = entry[7:0];
              end else begin
                walk_state = here;
                walk_dead  = 1'b1;
              end
            end
          end
          CMD_FINISH: begin
            here = (walk_len == 0) ? start_state : walk_state;
            if (walk_dead) begin
              want.matched  = 1'b0;
              want.dead_end = 1'b1;
            end else begin
              want.matched  = (int'(here) < NUM_STATES) ? accept_tbl[here] : 1'b0;
              want.dead_end = 1'b0;
            end
            verdict_q.push_back(want);
            walk_state = start_state;
            walk_dead  = 1'b0;
            walk_len   = 0;
          end
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= verdict_q.size();
      verdicts_o   <= verdict_cnt;
      matches_o    <= match_cnt;
      dead_ends_o  <= dead_cnt;
    end
  end

endmodule

// ----- test/table_dfa_string_matcher_tb.sv -----
`timescale 1ns / 1ps

module table_dfa_string_matcher_tb;
  import tdfa_pkg::*;

  localparam int RANDOM_BEATS = 150;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  logic       jitter_on;
  logic       long_hold_req;
  int         beats_sent;
  int         beats_by_cmd [4];
  int         start_writes;
  int         fail_count;
  int         pending;
  int         verdicts;
  int         match_total;
  int         dead_ends;

  tdfa_in_if  in_ch ();
  tdfa_out_if out_ch ();

  table_dfa_string_matcher DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  table_dfa_string_matcher_checker verdict_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .verdicts_o   (verdicts),
    .matches_o    (match_total),
    .dead_ends_o  (dead_ends)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog must allow for the clearing pass after reset, which writes all 65536 transition entries.
  initial begin
    #20_000_000;
    $display("Timed out with %0d verdicts outstanding.", pending);
    $display("simulation failed");
    $finish;
  end

  // Mostly short pauses, with an occasional long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_beat(cmd_e cmd, logic [7:0] sidx, logic [7:0] sym, logic [7:0] tgt,
                           logic tv, logic acc);
    int gap;
    gap = (jitter_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.state_index  <= sidx;
    in_ch.symbol       <= sym;
    in_ch.target_state <= tgt;
    in_ch.target_valid <= tv;
    in_ch.accept_value <= acc;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    beats_by_cmd[cmd]++;
  endtask

  task automatic put_trans(logic [7:0] st, logic [7:0] sym, logic [7:0] tgt, logic tv);
    send_beat(CMD_WR_TRANS, st, sym, tgt, tv, 1'($urandom));
  endtask

  task automatic put_accept(logic [7:0] st, logic acc);
    send_beat(CMD_WR_ACCEPT, st, 8'($urandom), 8'($urandom), 1'($urandom), acc);
  endtask

  task automatic feed(logic [7:0] sym);
    send_beat(CMD_FEED, 8'($urandom), sym, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic finish_str();
    send_beat(CMD_FINISH, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              1'($urandom));
  endtask

  // Stop offering, wait for every verdict, then let the pipeline settle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_start(logic [7:0] st);
    cfg_we    <= 1'b1;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_writes++;
  endtask

  initial begin : result_sink
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (jitter_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [7:0] states [6];
    logic [7:0] alpha [4];
    logic [7:0] loop_state;
    logic [7:0] loop_sym;
    int         prog;
    int         n_st;
    int         n_sym;
    int         n_str;
    int         len;
    int         pick;
    int         random_from;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_WR_TRANS;
    in_ch.state_index  = '0;
    in_ch.symbol       = '0;
    in_ch.target_state = '0;
    in_ch.target_valid = 1'b0;
    in_ch.accept_value = 1'b0;
    jitter_on          = 1'b1;
    long_hold_req      = 1'b0;
    beats_sent         = 0;
    start_writes       = 0;
    for (int i = 0; i < 4; i++) beats_by_cmd[i] = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_start(8'h00);

    // Empty strings are judged by the start state's accept flag alone.
    finish_str();
    put_accept(8'h00, 1'b1);
    finish_str();
    // Byte zero is an ordinary symbol: 0 -(00)-> FF -(FF)-> 0.
    put_trans(8'h00, 8'h00, 8'hFF, 1'b1);
    put_trans(8'hFF, 8'hFF, 8'h00, 1'b1);
    feed(8'h00);
    feed(8'hFF);
    finish_str();
    feed(8'h00);
    finish_str();
    put_accept(8'hFF, 1'b1);
    feed(8'h00);
    finish_str();
    // A missing transition kills the string; the byte after it is ignored.
    feed(8'h01);
    feed(8'h00);
    finish_str();
    // A table write in the middle of a string applies to its next byte.
    feed(8'h00);
    put_trans(8'hFF, 8'h01, 8'h80, 1'b1);
    feed(8'h01);
    finish_str();
    // Removing an entry makes the same byte a dead end.
    put_trans(8'h00, 8'h00, 8'hAA, 1'b0);
    feed(8'h00);
    finish_str();
    put_accept(8'hFF, 1'b0);

    quiesce();
    set_start(8'hFF);
    finish_str();

    random_from = beats_sent;
    prog        = 0;
    while (beats_sent - random_from < RANDOM_BEATS) begin
      quiesce();
      jitter_on = ($urandom_range(0, 3) != 0);

      // A small automaton over a few states and symbols keeps most strings alive.
      n_st = $urandom_range(2, 6);
      for (int i = 0; i < n_st; i++) states[i] = 8'($urandom);
      case ($urandom_range(0, 3))
        0:       states[0] = 8'h00;
        1:       states[0] = 8'hFF;
        default: ;
      endcase
      n_sym = $urandom_range(2, 4);
      for (int i = 0; i < n_sym; i++) alpha[i] = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        alpha[0]       = 8'h00;
        alpha[n_sym-1] = 8'hFF;
      end
      set_start(($urandom_range(0, 4) != 0) ? states[0] : 8'($urandom));

      for (int s = 0; s < n_st; s++) begin
        for (int a = 0; a < n_sym; a++) begin
          pick = $urandom_range(0, 9);
          if (pick < 8) begin
            put_trans(states[s], alpha[a], states[$urandom_range(0, n_st - 1)], 1'b1);
          end else if (pick == 8) begin
            put_trans(states[s], alpha[a], 8'($urandom), 1'b0);
          end
        end
        put_accept(states[s], 1'($urandom));
      end

      // Hold the result side off while short strings keep coming, so the
      // output register fills and the input side has to stall.
      if (prog == 0 || $urandom_range(0, 19) == 0) begin
        jitter_on     = 1'b0;
        long_hold_req = 1'b1;
        repeat (24) begin
          feed(alpha[$urandom_range(0, n_sym - 1)]);
          finish_str();
        end
      end

      n_str = $urandom_range(3, 10);
      for (int k = 0; k < n_str; k++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (int b = 0; b < len; b++) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            send_beat(cmd_e'(2'($urandom)), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
          end else if (pick == 1) begin
            feed(8'($urandom));
          end else begin
            feed(alpha[$urandom_range(0, n_sym - 1)]);
          end
        end
        finish_str();
      end
      prog++;
    end

    // Saturation at the length limit: a self loop carries the string to the
    // limit, and the bytes past it would otherwise kill it.
    quiesce();
    jitter_on  = 1'b0;
    loop_state = 8'($urandom);
    loop_sym   = 8'($urandom);
    set_start(loop_state);
    put_trans(loop_state, loop_sym, loop_state, 1'b1);
    put_trans(loop_state, loop_sym ^ 8'h5A, 8'($urandom), 1'b0);
    put_accept(loop_state, 1'b1);
    repeat (MAX_LENGTH) feed(loop_sym);
    repeat (4) feed(loop_sym ^ 8'h5A);
    finish_str();

    quiesce();
    $display("Sent %0d beats: %0d transition writes, %0d accept writes, %0d bytes, %0d finishes; %0d start-state writes.",
             beats_sent, beats_by_cmd[CMD_WR_TRANS], beats_by_cmd[CMD_WR_ACCEPT],
             beats_by_cmd[CMD_FEED], beats_by_cmd[CMD_FINISH], start_writes);
    $display("Checked %0d verdicts over %0d random automata: %0d matched, %0d dead-end.",
             verdicts, prog, match_total, dead_ends);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tdfa_pkg.sv
rtl/tdfa_in_if.sv
rtl/tdfa_out_if.sv
rtl/tdfa_trans_mem.sv
rtl/tdfa_acc_mem.sv
rtl/tdfa_walk.sv
rtl/table_dfa_string_matcher.sv
test/table_dfa_string_matcher_checker.sv
test/table_dfa_string_matcher_tb.sv
